// File: design/assert_macros.svh
// Assertion macros shared by the sprite rotation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, off while the given reset is asserted.
`define SPROT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset.
`define SPROT_ASSERT(label, prop, msg) \
  `SPROT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: design/sprot_pkg.sv
// Shared constants, types and trig helpers for the sprite rotation block.
package sprot_pkg;

  // Display and sprite limits
  localparam int ScreenWidth   = 320;
  localparam int ScreenHeight  = 240;
  localparam int MaxSpriteSide = 64;
  localparam int TrigFracBits  = 14;

  // Field widths fixed by the interface
  localparam int NumLanes  = 8;
  localparam int LaneIdxW  = 3;
  localparam int ByteW     = 8;
  localparam int SprDimW   = 7;
  localparam int OriginW   = 10;
  localparam int RotW      = 9;
  localparam int ColorW    = 16;
  localparam int CoordW    = 10;
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 3;

  // Derived widths
  localparam int RowW   = $clog2(MaxSpriteSide);
  localparam int SideW  = RowW + 1;
  localparam int ColW   = ((MaxSpriteSide + 7) / 8 > 1) ? $clog2((MaxSpriteSide + 7) / 8) : 1;
  localparam int BprW   = ColW + 1;
  localparam int SxW    = ColW + 3;
  localparam int DeltaW = ((SxW > RowW) ? SxW : RowW) + 1;
  localparam int CoefW  = TrigFracBits + 2;
  localparam int ProdW  = DeltaW + CoefW;
  localparam int SumW   = ProdW + 2;
  localparam int ShW    = SumW - TrigFracBits;
  localparam int PosW   = ((ShW > CoordW + 1) ? ShW : CoordW + 1) + 1;
  localparam int SatW   = (SprDimW > SideW) ? SprDimW : SideW;

  // Rescaling of the Q1.14 table to the working fraction
  localparam int TrigUp  = (TrigFracBits >= 14) ? TrigFracBits - 14 : 0;
  localparam int TrigDn  = (TrigFracBits < 14) ? 14 - TrigFracBits : 0;
  localparam int TrigRnd = (TrigFracBits < 14) ? (1 << (13 - TrigFracBits)) : 0;

  localparam logic [RotW-1:0] FullTurn    = RotW'(360);
  localparam logic [RotW-1:0] QuarterTurn = RotW'(90);
  localparam logic [RotW-1:0] HalfTurn    = RotW'(180);
  localparam logic [RotW-1:0] ThreeQuarter = RotW'(270);

  // sin of whole degrees 0..90 in Q1.14
  localparam logic [14:0] SinQ14 [91] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997, 15'd2280,
    15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240, 15'd4516,
    15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402, 15'd6664,
    15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438, 15'd8682,
    15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531,
    15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
    15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330,
    15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191,
    15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826,
    15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16224,
    15'd16262, 15'd16294, 15'd16322, 15'd16343, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSpriteWidth  = 3'd0,
    CfgSpriteHeight = 3'd1,
    CfgOriginX      = 3'd2,
    CfgOriginY      = 3'd3,
    CfgRotation     = 3'd4,
    CfgDrawColor    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    Quad0,
    Quad90,
    Quad180,
    Quad270
  } quad_e;

  typedef struct packed {
    logic signed [CoefW-1:0] s;
    logic signed [CoefW-1:0] c;
  } trig_t;

  // Byte with its sprite position, one per pipeline slot
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] bits;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
  } track_t;

  // One lane's plotted pixel
  typedef struct packed {
    logic              hit;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } pix_t;

  // Clamp a configured side to the largest supported sprite
  function automatic logic [SideW-1:0] sat_side(input logic [SprDimW-1:0] v);
    return (SatW'(v) > SatW'(MaxSpriteSide)) ? SideW'(MaxSpriteSide) : SideW'(v);
  endfunction

  // Table entry rescaled to the working fraction
  function automatic logic [CoefW-2:0] trig_scaled(input logic [6:0] d);
    logic [31:0] v;
    v = 32'(SinQ14[d]) << TrigUp;
    v = (v + 32'(TrigRnd)) >> TrigDn;
    return v[CoefW-2:0];
  endfunction

  // sin and cos of a whole-degree angle by quadrant folding
  function automatic trig_t trig_coef(input logic [RotW-1:0] rot);
    logic [RotW-1:0]         ang;
    logic [RotW-1:0]         rem;
    quad_e                   q;
    logic [6:0]              r;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    trig_t                   t;
    ang = (rot >= FullTurn) ? rot - FullTurn : rot;
    if (ang < QuarterTurn) begin
      q   = Quad0;
      rem = ang;
    end else if (ang < HalfTurn) begin
      q   = Quad90;
      rem = ang - QuarterTurn;
    end else if (ang < ThreeQuarter) begin
      q   = Quad180;
      rem = ang - HalfTurn;
    end else begin
      q   = Quad270;
      rem = ang - ThreeQuarter;
    end
    r = rem[6:0];
    a = $signed({1'b0, trig_scaled(r)});
    b = $signed({1'b0, trig_scaled(7'd90 - r)});
    unique case (q)
      Quad0: begin
        t.s = a;
        t.c = b;
      end
      Quad90: begin
        t.s = b;
        t.c = -a;
      end
      Quad180: begin
        t.s = -a;
        t.c = -b;
      end
      default: begin
        t.s = -b;
        t.c = a;
      end
    endcase
    return t;
  endfunction

  // Shift out the fraction, rounding toward zero
  function automatic logic signed [ShW-1:0] trunc_shift(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] a;
    a = v[SumW-1] ? v + SumW'((1 << TrigFracBits) - 1) : v;
    return $signed(a[SumW-1:TrigFracBits]);
  endfunction

endpackage

// File: design/sprot_track.sv
// Byte position tracker: column and row counters and the first pipeline slot.
`include "assert_macros.svh"

module sprot_track
  import sprot_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] bitmap_byte_i,
  input  logic             sprite_start_i,
  input  logic [SideW-1:0] width_i,
  output track_t           item_o
);

  logic                       accept;
  logic [ColW-1:0]            col_q, col_d, col_cur;
  logic [RowW-1:0]            row_q, row_d, row_cur;
  logic [SideW:0]             bpr_wide;
  logic [BprW-1:0]            bpr;
  logic                       row_end;
  track_t                     item_q, item_d;

  assign accept = in_valid_i && en_i;

  // Work out this byte's place and the next one
  always_comb begin
    col_cur  = sprite_start_i ? '0 : col_q;
    row_cur  = sprite_start_i ? '0 : row_q;
    bpr_wide = ({1'b0, width_i} + (SideW + 1)'(7)) >> 3;
    bpr      = BprW'(bpr_wide);
    if (bpr == '0) begin
      bpr = BprW'(1);
    end
    row_end = (BprW'(col_cur) + BprW'(1)) >= bpr;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = (row_cur == RowW'(MaxSpriteSide - 1)) ? '0 : row_cur + RowW'(1);
      end else begin
        col_d = col_cur + ColW'(1);
        row_d = row_cur;
      end
    end
    item_d.valid = in_valid_i;
    item_d.bits  = bitmap_byte_i;
    item_d.col   = col_cur;
    item_d.row   = row_cur;
  end

  // Hold counters and the slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      item_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (en_i) begin
        item_q <= item_d;
      end
    end
  end

  assign item_o = item_q;

  `SPROT_ASSERT(a_start_restarts, accept && sprite_start_i |=> item_q.col == '0 && item_q.row == '0, "sprite start did not restart position")
  `SPROT_ASSERT(a_slot_holds, item_q.valid && !en_i |=> item_q.valid && $stable(item_q.bits), "stalled slot changed")
  `SPROT_ASSERT(a_accept_fills, accept |=> item_q.valid, "accepted byte lost")

endmodule

// File: design/sprot_lane.sv
// One rotation lane: rotates one pixel of the byte and checks it against the display.
module sprot_lane
  import sprot_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [LaneIdxW-1:0]      lane_i,
  input  track_t                   item_i,
  input  logic [SideW-1:0]         width_i,
  input  logic [RowW-1:0]          half_w_i,
  input  logic                     row_ok_i,
  input  trig_t                    trig_i,
  input  logic signed [ProdW-1:0]  dy_sin_i,
  input  logic signed [ProdW-1:0]  dy_cos_i,
  input  logic signed [SumW-1:0]   bias_x_i,
  input  logic signed [SumW-1:0]   bias_y_i,
  input  logic [OriginW-1:0]       origin_x_i,
  input  logic [OriginW-1:0]       origin_y_i,
  output pix_t                     pix_o
);

  localparam logic signed [PosW-1:0] ScrW = PosW'(ScreenWidth);
  localparam logic signed [PosW-1:0] ScrH = PosW'(ScreenHeight);

  logic [SxW-1:0]           sx;
  logic                     bit_set;
  logic                     active;
  logic signed [DeltaW-1:0] dx;
  logic signed [ProdW-1:0]  dxc_d, dxs_d, dxc_q, dxs_q;
  logic                     active_q;
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic signed [ShW-1:0]    tx, ty;
  logic signed [PosW-1:0]   rx, ry;
  pix_t                     pix_d, pix_q;

  // Find the pixel's column and multiply its offset
  always_comb begin
    sx      = {item_i.col, lane_i};
    bit_set = item_i.bits[LaneIdxW'(NumLanes - 1) - lane_i];
    active  = item_i.valid && bit_set && row_ok_i && (SideW'(sx) < width_i);
    dx      = $signed(DeltaW'(sx)) - $signed(DeltaW'(half_w_i));
    dxc_d   = ProdW'(dx * trig_i.c);
    dxs_d   = ProdW'(dx * trig_i.s);
  end

  // Combine with the row terms, drop the fraction, place on screen
  always_comb begin
    sum_x = SumW'(dxc_q) - SumW'(dy_sin_i) + bias_x_i;
    sum_y = SumW'(dxs_q) + SumW'(dy_cos_i) + bias_y_i;
    tx    = trunc_shift(sum_x);
    ty    = trunc_shift(sum_y);
    rx    = PosW'(tx) + $signed(PosW'(origin_x_i));
    ry    = PosW'(ty) + $signed(PosW'(origin_y_i));
    pix_d.hit = active_q && !rx[PosW-1] && (rx < ScrW) && !ry[PosW-1] && (ry < ScrH);
    pix_d.x   = rx[CoordW-1:0];
    pix_d.y   = ry[CoordW-1:0];
  end

  // Advance lane stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pix_q    <= '0;
    end else if (en_i) begin
      active_q <= active;
      pix_q    <= pix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxc_q <= dxc_d;
      dxs_q <= dxs_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// File: design/sprot_merge.sv
// Merge stage: hands the lane results out one pixel per transaction in bit order.
`include "assert_macros.svh"

module sprot_merge
  import sprot_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pix_t              pix_i [NumLanes],
  input  logic              out_ready_i,
  input  logic [ColorW-1:0] color_i,
  output logic              load_o,
  output logic              out_valid_o,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic [ColorW-1:0] pixel_color_o,
  output logic              last_pixel_o
);

  logic [NumLanes-1:0] mask_q, mask_d;
  logic [NumLanes-1:0] hits;
  logic [NumLanes-1:0] sel;
  logic [NumLanes-1:0] rest;
  logic [CoordW-1:0]   x_q [NumLanes];
  logic [CoordW-1:0]   y_q [NumLanes];
  logic                take;

  // Pick the leftmost pending pixel
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      hits[i] = pix_i[i].hit;
    end
    sel          = mask_q & (~mask_q + NumLanes'(1));
    rest         = mask_q & ~sel;
    out_valid_o  = |mask_q;
    last_pixel_o = (rest == '0);
    take         = out_valid_o && out_ready_i;
    load_o       = !out_valid_o || (take && last_pixel_o);
    pixel_x_o    = '0;
    pixel_y_o    = '0;
    for (int i = 0; i < NumLanes; i++) begin
      pixel_x_o = pixel_x_o | (x_q[i] & {CoordW{sel[i]}});
      pixel_y_o = pixel_y_o | (y_q[i] & {CoordW{sel[i]}});
    end
    if (load_o) begin
      mask_d = hits;
    end else if (take) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end
  end

  assign pixel_color_o = color_i;

  // Hold pending pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      for (int i = 0; i < NumLanes; i++) begin
        x_q[i] <= pix_i[i].x;
        y_q[i] <= pix_i[i].y;
      end
    end
  end

  `SPROT_ASSERT(a_group_continues, take && !last_pixel_o |=> out_valid_o, "pixel group ended early")
  `SPROT_ASSERT(a_load_shows, load_o && (hits != '0) |=> out_valid_o, "loaded pixels not shown")
  `SPROT_ASSERT(a_stall_holds, out_valid_o && !out_ready_i |=> $stable(mask_q), "pending pixels changed in stall")

endmodule

// File: design/sprite_rotate_plot.sv
// A byte accepted passes the tracker slot, the lane product and pixel registers and the
// merge mask before its first pixel shows on the output. Throughput: one byte per cycle while
// each byte plots at most one pixel and the receiver is ready; otherwise a byte holds the input
// until its pixels, up to 8, have left through the single output port, one per transaction.
// Reset: row and column counters clear, registers take their defaults, pipeline empties.
module sprite_rotate_plot
  import sprot_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    bitmap_byte_i,
  input  logic                sprite_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CoordW-1:0]   pixel_x_o,
  output logic [CoordW-1:0]   pixel_y_o,
  output logic [ColorW-1:0]   pixel_color_o,
  output logic                last_pixel_o
);

  logic [SprDimW-1:0]      width_q, height_q;
  logic [OriginW-1:0]      origin_x_q, origin_y_q;
  logic [RotW-1:0]         rot_q;
  logic [ColorW-1:0]       color_q;

  logic                    en;
  logic [SideW-1:0]        w_sat, h_sat;
  logic [RowW-1:0]         half_w, half_h;
  track_t                  item;
  trig_t                   trig;
  logic                    row_ok;
  logic signed [DeltaW-1:0] dy;
  logic signed [ProdW-1:0] dy_sin_d, dy_cos_d, dy_sin_q, dy_cos_q;
  logic signed [SumW-1:0]  bias_x, bias_y;
  pix_t                    pix [NumLanes];

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SprDimW'(8);
      height_q   <= SprDimW'(8);
      origin_x_q <= '0;
      origin_y_q <= '0;
      rot_q      <= '0;
      color_q    <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSpriteWidth:  width_q    <= cfg_data_i[SprDimW-1:0];
        CfgSpriteHeight: height_q   <= cfg_data_i[SprDimW-1:0];
        CfgOriginX:      origin_x_q <= cfg_data_i[OriginW-1:0];
        CfgOriginY:      origin_y_q <= cfg_data_i[OriginW-1:0];
        CfgRotation:     rot_q      <= cfg_data_i[RotW-1:0];
        CfgDrawColor:    color_q    <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  // Derive sprite geometry and row terms
  always_comb begin
    w_sat    = sat_side(width_q);
    h_sat    = sat_side(height_q);
    half_w   = RowW'(w_sat >> 1);
    half_h   = RowW'(h_sat >> 1);
    trig     = trig_coef(rot_q);
    row_ok   = SideW'(item.row) < h_sat;
    dy       = $signed(DeltaW'(item.row)) - $signed(DeltaW'(half_h));
    dy_sin_d = ProdW'(dy * trig.s);
    dy_cos_d = ProdW'(dy * trig.c);
    bias_x   = $signed(SumW'(half_w) << TrigFracBits);
    bias_y   = $signed(SumW'(half_h) << TrigFracBits);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dy_sin_q <= dy_sin_d;
      dy_cos_q <= dy_cos_d;
    end
  end

  assign in_ready_o = en;

  sprot_track u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .in_valid_i     (in_valid_i),
    .bitmap_byte_i  (bitmap_byte_i),
    .sprite_start_i (sprite_start_i),
    .width_i        (w_sat),
    .item_o         (item)
  );

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    sprot_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .lane_i     (LaneIdxW'(g)),
      .item_i     (item),
      .width_i    (w_sat),
      .half_w_i   (half_w),
      .row_ok_i   (row_ok),
      .trig_i     (trig),
      .dy_sin_i   (dy_sin_q),
      .dy_cos_i   (dy_cos_q),
      .bias_x_i   (bias_x),
      .bias_y_i   (bias_y),
      .origin_x_i (origin_x_q),
      .origin_y_i (origin_y_q),
      .pix_o      (pix[g])
    );
  end

  sprot_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix),
    .out_ready_i   (out_ready_i),
    .color_i       (color_q),
    .load_o        (en),
    .out_valid_o   (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// File: bench/sprite_rotate_plot_tb.sv
// Self-checking testbench for the streamed sprite rotation and plot block.
module sprite_rotate_plot_tb
  import sprot_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBytes = 180;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 400000;
  localparam int MaxBurst    = 40;

  // Sine of whole degrees 0..90 in Q1.14
  localparam int SineQ14 [91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16224, 16262, 16294, 16322, 16343, 16362, 16374, 16382,
    16384
  };

  typedef struct packed {
    logic [ByteW-1:0] bits;
    logic             start;
  } byte_item_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic              last;
  } plot_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [ByteW-1:0]    bitmap_byte_i  = '0;
  logic                sprite_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [CoordW-1:0]   pixel_x_o;
  logic [CoordW-1:0]   pixel_y_o;
  logic [ColorW-1:0]   pixel_color_o;
  logic                last_pixel_o;

  sprite_rotate_plot dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .bitmap_byte_i,
    .sprite_start_i,
    .out_valid_o,
    .out_ready_i,
    .pixel_x_o,
    .pixel_y_o,
    .pixel_color_o,
    .last_pixel_o
  );

  // Shadow registers and sprite position of the expected behavior
  logic [SprDimW-1:0] shadow_width    = SprDimW'(8);
  logic [SprDimW-1:0] shadow_height   = SprDimW'(8);
  logic [OriginW-1:0] shadow_origin_x = '0;
  logic [OriginW-1:0] shadow_origin_y = '0;
  logic [RotW-1:0]    shadow_rotation = '0;
  logic [ColorW-1:0]  shadow_color    = '1;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  byte_item_t  byte_q [$];
  plot_t       pixel_q [$];
  byte_item_t  next_byte;
  plot_t       want_pixel;
  plot_t       got_pixel;

  int sender_idle_pct   = 24;
  int receiver_idle_pct = 74;
  int bytes_accepted    = 0;
  int pixels_checked    = 0;
  int mismatch_count    = 0;
  int settings_written  = 0;
  int cycle_count       = 0;

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Table entry at the working fraction
  function automatic longint trig_q(input int unsigned deg);
    return longint'(SineQ14[deg]) <<< (TrigFracBits - 14);
  endfunction

  // Drop the fraction, rounding toward zero
  function automatic longint drop_fraction(input longint v);
    if (v >= 0) return v >>> TrigFracBits;
    return -((-v) >>> TrigFracBits);
  endfunction

  // Rotate the set pixels of one byte and queue those that land on screen
  task automatic plot_byte(input logic [ByteW-1:0] bits, input logic start);
    int unsigned w, h, bpr, ang, rem, sx;
    quad_e       quad;
    longint      s, c, hw, hh, dx, dy, rx, ry;
    plot_t       hits [8];
    int          found;
    found = 0;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    w   = (shadow_width > MaxSpriteSide) ? MaxSpriteSide : shadow_width;
    h   = (shadow_height > MaxSpriteSide) ? MaxSpriteSide : shadow_height;
    bpr = (w + 7) / 8;
    if (bpr == 0) bpr = 1;
    ang  = shadow_rotation % 360;
    quad = quad_e'(ang / 90);
    rem  = ang % 90;
    case (quad)
      Quad0: begin
        s = trig_q(rem);
        c = trig_q(90 - rem);
      end
      Quad90: begin
        s = trig_q(90 - rem);
        c = -trig_q(rem);
      end
      Quad180: begin
        s = -trig_q(rem);
        c = -trig_q(90 - rem);
      end
      default: begin
        s = -trig_q(90 - rem);
        c = trig_q(rem);
      end
    endcase
    if (row_pos < h) begin
      hw = w / 2;
      hh = h / 2;
      dy = longint'(row_pos) - hh;
      for (int b = 0; b < 8; b++) begin
        sx = col_pos * 8 + b;
        if (sx >= w) break;
        if (!bits[7-b]) continue;
        dx = longint'(sx) - hw;
        rx = shadow_origin_x +
             drop_fraction(dx * c - dy * s + (hw <<< TrigFracBits));
        ry = shadow_origin_y +
             drop_fraction(dx * s + dy * c + (hh <<< TrigFracBits));
        if (rx < 0 || rx >= ScreenWidth || ry < 0 || ry >= ScreenHeight) continue;
        hits[found].x     = CoordW'(rx);
        hits[found].y     = CoordW'(ry);
        hits[found].color = shadow_color;
        hits[found].last  = 1'b0;
        found++;
      end
      for (int k = 0; k < found; k++) begin
        hits[k].last = (k == found - 1);
        pixel_q.push_back(hits[k]);
      end
    end
    // Advance to the next byte column, wrapping rows at the largest side
    if (col_pos + 1 >= bpr) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % MaxSpriteSide;
    end else begin
      col_pos++;
    end
  endtask

  // Driver: present queued bytes, predict each accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        plot_byte(bitmap_byte_i, sprite_start_i);
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_byte = byte_q.pop_front();
          in_valid_i     <= 1'b1;
          bitmap_byte_i  <= next_byte.bits;
          sprite_start_i <= next_byte.start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each pixel transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_pixel = '{x: pixel_x_o, y: pixel_y_o, color: pixel_color_o,
                      last: last_pixel_o};
        if (pixel_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                   pixel_x_o, pixel_y_o, pixel_color_o, last_pixel_o);
        end else begin
          want_pixel = pixel_q.pop_front();
          pixels_checked++;
          if (got_pixel !== want_pixel) begin
            mismatch_count++;
            $display("%0t: pixel mismatch expected x=%0d y=%0d color=%h last=%b",
                     $time, want_pixel.x, want_pixel.y, want_pixel.color,
                     want_pixel.last);
            $display("%0t:                  actual x=%0d y=%0d color=%h last=%b",
                     $time, got_pixel.x, got_pixel.y, got_pixel.color,
                     got_pixel.last);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d pixels still pending", cycle_count,
               pixel_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] bits, input logic start);
    byte_q.push_back('{bits: bits, start: start});
  endtask

  // Queue a run of random bytes; a noisy run scatters sprite starts
  task automatic queue_sprite(input int unsigned count, input bit noisy);
    for (int unsigned k = 0; k < count; k++) begin
      push_byte(($urandom_range(3) == 0) ? 8'hFF : ByteW'($urandom()),
                noisy ? ($urandom_range(7) == 0) : (k == 0));
    end
  endtask

  // Hold until every byte is accepted and every pixel has come out
  task automatic settle_block();
    while (byte_q.size() != 0 || in_valid_i || pixel_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(value);
    case (idx)
      CfgSpriteWidth:  shadow_width    = SprDimW'(value);
      CfgSpriteHeight: shadow_height   = SprDimW'(value);
      CfgOriginX:      shadow_origin_x = OriginW'(value);
      CfgOriginY:      shadow_origin_y = OriginW'(value);
      CfgRotation:     shadow_rotation = RotW'(value);
      default:         shadow_color    = ColorW'(value);
    endcase
  endtask

  // Write all registers back to back; the block must be idle
  task automatic apply_setting(input int unsigned w, input int unsigned h,
                               input int unsigned ox, input int unsigned oy,
                               input int unsigned rot, input int unsigned color);
    write_reg(CfgSpriteWidth, w);
    write_reg(CfgSpriteHeight, h);
    write_reg(CfgOriginX, ox);
    write_reg(CfgOriginY, oy);
    write_reg(CfgRotation, rot);
    write_reg(CfgDrawColor, color);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_written++;
  endtask

  initial begin : stimulus
    int          random_bytes;
    int unsigned w, h, ox, oy, w_eff, h_eff, bpr, count, pick;
    bit          noisy;
    random_bytes = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: 8x8 sprite at the corner, no rotation
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    settle_block();

    // Oversized sides saturate, angle past a full turn folds back
    apply_setting(127, 100, 100, 100, 450, 16'h8001);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hFF, 1'b0);
    settle_block();

    // Zero width draws nothing, a row is one byte
    apply_setting(0, 5, 1023, 5, 511, 16'h7FFE);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    settle_block();

    // Zero height draws nothing
    apply_setting(8, 0, 5, 1023, 360, 16'hFFFF);
    push_byte(8'hFF, 1'b1);
    settle_block();

    // Padding bits, a row past the height, pixels off the right and bottom edges
    apply_setting(5, 3, 318, 238, 180, 16'h00FF);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    settle_block();

    // Leave the column at two bytes into a wide row
    apply_setting(24, 4, 10, 20, 359, 16'h0000);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h0F, 1'b0);
    settle_block();

    // Narrow the row: the stale column is taken, then the row advances
    apply_setting(8, 8, 50, 60, 270, 16'h1234);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hC3, 1'b0);
    settle_block();

    // Long stream without a restart: the row counter wraps and drawing resumes
    apply_setting(8, 4, 20, 30, 30, 16'hABCD);
    queue_sprite(70, 1'b0);
    settle_block();

    while (random_bytes < RandomBytes) begin
      // Idle mix by progress through the random part
      if (random_bytes < RandomBytes / 3) begin
        sender_idle_pct   = 24;
        receiver_idle_pct = 74;
      end else if (random_bytes < 2 * RandomBytes / 3) begin
        sender_idle_pct   = 74;
        receiver_idle_pct = 24;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end

      // Mostly small sprites placed near the screen
      pick = $urandom_range(99);
      if (pick < 70) w = $urandom_range(1, 16);
      else if (pick < 90) w = $urandom_range(17, 64);
      else if (pick < 95) w = 0;
      else w = $urandom_range(65, 127);
      pick = $urandom_range(99);
      if (pick < 80) h = $urandom_range(1, 8);
      else if (pick < 95) h = $urandom_range(9, 24);
      else if (pick < 97) h = 0;
      else h = $urandom_range(65, 127);
      if ($urandom_range(99) < 85) begin
        ox = $urandom_range(0, 330);
        oy = $urandom_range(0, 250);
      end else begin
        ox = $urandom_range(0, 1023);
        oy = $urandom_range(0, 1023);
      end
      apply_setting(w, h, ox, oy, $urandom_range(0, 511), $urandom_range(0, 65535));

      w_eff = (w > MaxSpriteSide) ? MaxSpriteSide : w;
      h_eff = (h > MaxSpriteSide) ? MaxSpriteSide : h;
      bpr   = (w_eff + 7) / 8;
      if (bpr == 0) bpr = 1;
      repeat ($urandom_range(1, 3)) begin
        noisy = ($urandom_range(99) < 20);
        count = h_eff * bpr;
        if (count > MaxBurst) count = MaxBurst;
        if (count < 2) count = 2;
        if (noisy) count += $urandom_range(1, 6);
        queue_sprite(count, noisy);
        random_bytes += count;
      end
      settle_block();
    end

    settle_block();
    $display("Run covered %0d bytes under %0d register settings, %0d pixels compared",
             bytes_accepted, settings_written, pixels_checked);
    $display("Idle mixes: slow receiver, slow sender, then back-to-back; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pixel_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
